>>> rtl/core/nhpw_pkg.sv
// nhpw_pkg: shared widths, constants, codes and controller/datapath command types
// for the next-hop pending-weight block. No dependencies.
package nhpw_pkg;

   localparam int DELAY_BITS   = 20;
   localparam int COUNT_BITS   = 16;
   localparam int WORD_BITS    = 32;
   localparam int ALPHA_BITS   = 16;
   localparam int OUT_CNT_BITS = 16;
   localparam int FRAC_BITS    = 16;

   // multiplier B operand covers both alpha complement and the delay
   localparam int MUL_B_BITS   = (DELAY_BITS > ALPHA_BITS + 1) ? DELAY_BITS : ALPHA_BITS + 1;
   localparam int PROD_BITS    = WORD_BITS + MUL_B_BITS;
   localparam int DEN_BITS     = WORD_BITS + DELAY_BITS;
   localparam int DIV_CNT_BITS = $clog2(WORD_BITS);

   typedef logic [DELAY_BITS-1:0]   delay_type;
   typedef logic [COUNT_BITS-1:0]   count_type;
   typedef logic [WORD_BITS-1:0]    word_type;
   typedef logic [ALPHA_BITS-1:0]   alpha_type;
   typedef logic [MUL_B_BITS-1:0]   mul_b_type;
   typedef logic [PROD_BITS-1:0]    prod_type;
   typedef logic [DEN_BITS-1:0]     den_type;
   typedef logic [DIV_CNT_BITS-1:0] div_cnt_type;

   localparam alpha_type ALPHA_RESET = alpha_type'(58982);
   localparam logic [ALPHA_BITS:0] ALPHA_ONE = (ALPHA_BITS+1)'(1) << ALPHA_BITS;
   localparam word_type  ONE_Q16     = word_type'(65536);
   localparam word_type  TENTH_Q16   = word_type'(6554);
   localparam word_type  WORD_MAX    = '1;
   localparam count_type COUNT_MAX   = '1;
   localparam prod_type  ROUND_HALF  = prod_type'(1) << (FRAC_BITS - 1);
   localparam div_cnt_type DIV_LAST  = div_cnt_type'(WORD_BITS - 1);

   typedef enum logic [1:0] {
      OP_UPDATE    = 2'd0,
      OP_SET_DELAY = 2'd1,
      OP_RESET     = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_COUNT,
      S_MUL_OLD,
      S_MUL_NEW,
      S_AVG,
      S_MUL_DEN,
      S_DEN,
      S_START,
      S_DIV,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MUL_AVG_ALPHA,
      MUL_COUNT_BETA,
      MUL_AVG_DELAY
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      logic        count_step;
      logic        set_delay;
      logic        clear_state;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_en;
      logic        avg_en;
      logic        den_en;
      logic        div_init;
      logic        div_step;
      logic        div_last;
      logic        sat_load;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   overflow;
   } status_type;

endpackage

>>> rtl/core/nexthop_pending_weight.sv
// nexthop_pending_weight: top level; joins the sequencer (nhpw_ctrl) and the
// datapath (nhpw_dp). Depends on nhpw_pkg.
//
// Load-balancing weight of one next hop. One transaction in, one result out.
// An update moves the pending count, smooths it (alpha in Q0.16) and returns
// weight = hop_delay / (avg * least_delay) in Q16.16, or 1/avg without a usable
// delay; overflow saturates to all ones with weight_saturated set. An update
// uses the one shared 32x20 multiplier, then, unless the quotient overflows,
// the radix-2 divider, one quotient bit per cycle. Set-delay, reset and the
// unused code go from decode straight to finish. Items are processed one at
// a time; the next one is accepted while the previous result waits in the
// output register. The user writes smoothing_alpha through csr_write_enable/
// csr_write_data only while the block is idle; the block does not enforce it.
module nexthop_pending_weight (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic        req_increment,
   input  logic        req_least_delay_known,
   input  logic [19:0] req_least_delay,
   input  logic [19:0] req_new_delay,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_weight,
   output logic        rsp_weight_saturated,
   output logic [15:0] rsp_pending_count,
   output logic [31:0] rsp_average_pending
);

   nhpw_pkg::cmd_type    cmd;
   nhpw_pkg::status_type status;

   nhpw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nhpw_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_operation         (req_operation),
      .req_increment         (req_increment),
      .req_least_delay_known (req_least_delay_known),
      .req_least_delay       (req_least_delay),
      .req_new_delay         (req_new_delay),
      .rsp_weight            (rsp_weight),
      .rsp_weight_saturated  (rsp_weight_saturated),
      .rsp_pending_count     (rsp_pending_count),
      .rsp_average_pending   (rsp_average_pending)
   );

endmodule

>>> rtl/core/nhpw_dp.sv
// nhpw_dp: datapath of the next-hop pending-weight block: hop state, alpha register,
// shared multiplier, radix-2 restoring divider and result register. Uses nhpw_pkg.
module nhpw_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  nhpw_pkg::cmd_type           cmd,
   output nhpw_pkg::status_type        status,
   input  logic                        csr_write_enable,
   input  logic [15:0]                 csr_write_data,
   input  logic [1:0]                  req_operation,
   input  logic                        req_increment,
   input  logic                        req_least_delay_known,
   input  logic [19:0]                 req_least_delay,
   input  logic [19:0]                 req_new_delay,
   output logic [31:0]                 rsp_weight,
   output logic                        rsp_weight_saturated,
   output logic [15:0]                 rsp_pending_count,
   output logic [31:0]                 rsp_average_pending
);

   // architectural state
   nhpw_pkg::alpha_type alpha_ff;
   nhpw_pkg::count_type pending_ff, pending_in;
   nhpw_pkg::word_type  avg_ff, avg_in;
   nhpw_pkg::delay_type hop_delay_ff;
   nhpw_pkg::word_type  weight_ff;

   // captured transaction
   nhpw_pkg::op_type    op_ff;
   logic                inc_ff;
   logic                known_ff;
   nhpw_pkg::delay_type least_delay_ff;
   nhpw_pkg::delay_type new_delay_ff;
   logic                sat_ff;

   // arithmetic
   nhpw_pkg::word_type  mul_a;
   nhpw_pkg::mul_b_type mul_b;
   nhpw_pkg::prod_type  prod, prod_ff;
   nhpw_pkg::word_type  acc_ff;
   logic [nhpw_pkg::PROD_BITS:0] avg_sum;
   logic                use_delay;
   nhpw_pkg::delay_type num_high;
   nhpw_pkg::den_type   den_in, den_ff;
   nhpw_pkg::den_type   rem_ff, rem_in;
   logic [nhpw_pkg::DEN_BITS:0] rem_shift;
   logic                rem_ge;
   nhpw_pkg::word_type  quot_ff;

   // rsp register
   nhpw_pkg::word_type  rsp_weight_ff;
   logic                rsp_sat_ff;
   logic [15:0]         rsp_count_ff;
   nhpw_pkg::word_type  rsp_avg_ff;

   always_comb begin
      pending_in = pending_ff;
      if (inc_ff) begin
         if (pending_ff != nhpw_pkg::COUNT_MAX) pending_in = pending_ff + 1'b1;
      end else if (pending_ff != '0) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_comb begin
      case (cmd.mul_sel)
         nhpw_pkg::MUL_AVG_ALPHA: begin
            mul_a = avg_ff;
            mul_b = nhpw_pkg::mul_b_type'(alpha_ff);
         end
         nhpw_pkg::MUL_COUNT_BETA: begin
            mul_a = nhpw_pkg::word_type'(pending_ff);
            mul_b = nhpw_pkg::mul_b_type'(nhpw_pkg::ALPHA_ONE - {1'b0, alpha_ff});
         end
         nhpw_pkg::MUL_AVG_DELAY: begin
            mul_a = avg_ff;
            mul_b = nhpw_pkg::mul_b_type'(least_delay_ff);
         end
         default: begin
            mul_a = avg_ff;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // new average = rounded old term + count term, saturated, zero forced to 0.1
   assign avg_sum = {1'b0, prod_ff} + (nhpw_pkg::PROD_BITS+1)'(acc_ff);

   always_comb begin
      if (|avg_sum[nhpw_pkg::PROD_BITS:nhpw_pkg::WORD_BITS]) begin
         avg_in = nhpw_pkg::WORD_MAX;
      end else if (avg_sum == '0) begin
         avg_in = nhpw_pkg::TENTH_Q16;
      end else begin
         avg_in = avg_sum[nhpw_pkg::WORD_BITS-1:0];
      end
   end

   assign use_delay = known_ff && (hop_delay_ff != '0);
   assign num_high  = use_delay ? hop_delay_ff : nhpw_pkg::delay_type'(1);
   assign den_in    = use_delay ? prod_ff[nhpw_pkg::DEN_BITS-1:0]
                                : nhpw_pkg::den_type'(avg_ff);

   // quotient exceeds 32 bits (or divisor is zero) when the numerator's
   // upper word is not below the divisor
   assign status.overflow = nhpw_pkg::den_type'(num_high) >= den_ff;
   assign status.op       = op_ff;

   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = rem_shift >= {1'b0, den_ff};
   always_comb begin
      if (rem_ge) begin
         rem_in = nhpw_pkg::den_type'(rem_shift - {1'b0, den_ff});
      end else begin
         rem_in = rem_shift[nhpw_pkg::DEN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= nhpw_pkg::ALPHA_RESET;
         pending_ff   <= '0;
         avg_ff       <= nhpw_pkg::ONE_Q16;
         hop_delay_ff <= '0;
         weight_ff    <= nhpw_pkg::ONE_Q16;
      end else begin
         if (csr_write_enable) alpha_ff <= csr_write_data;
         if (cmd.clear_state) begin
            pending_ff   <= '0;
            avg_ff       <= nhpw_pkg::ONE_Q16;
            hop_delay_ff <= '0;
            weight_ff    <= nhpw_pkg::ONE_Q16;
         end else begin
            if (cmd.count_step) pending_ff <= pending_in;
            if (cmd.avg_en) avg_ff <= avg_in;
            if (cmd.set_delay && (new_delay_ff != '0)) hop_delay_ff <= new_delay_ff;
            if (cmd.sat_load) weight_ff <= nhpw_pkg::WORD_MAX;
            if (cmd.div_last) weight_ff <= {quot_ff[nhpw_pkg::WORD_BITS-2:0], rem_ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff          <= nhpw_pkg::op_type'(req_operation);
         inc_ff         <= req_increment;
         known_ff       <= req_least_delay_known;
         least_delay_ff <= nhpw_pkg::delay_type'(req_least_delay);
         new_delay_ff   <= nhpw_pkg::delay_type'(req_new_delay);
         sat_ff         <= 1'b0;
      end else if (cmd.sat_load) begin
         sat_ff <= 1'b1;
      end
      if (cmd.mul_en) prod_ff <= prod;
      if (cmd.acc_en) begin
         acc_ff <= nhpw_pkg::word_type'((prod_ff + nhpw_pkg::ROUND_HALF) >> nhpw_pkg::FRAC_BITS);
      end
      if (cmd.den_en) den_ff <= den_in;
      if (cmd.div_init) begin
         rem_ff  <= nhpw_pkg::den_type'(num_high);
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[nhpw_pkg::WORD_BITS-2:0], rem_ge};
      end
      if (cmd.load_rsp) begin
         rsp_weight_ff <= weight_ff;
         rsp_sat_ff    <= sat_ff;
         rsp_count_ff  <= nhpw_pkg::OUT_CNT_BITS'(pending_ff);
         rsp_avg_ff    <= avg_ff;
      end
   end

   assign rsp_weight           = rsp_weight_ff;
   assign rsp_weight_saturated = rsp_sat_ff;
   assign rsp_pending_count    = rsp_count_ff;
   assign rsp_average_pending  = rsp_avg_ff;

endmodule

>>> rtl/core/nhpw_ctrl.sv
// nhpw_ctrl: sequencer of the next-hop pending-weight block; drives datapath commands
// and owns both handshakes. Uses nhpw_pkg.
module nhpw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  nhpw_pkg::status_type  status,
   output nhpw_pkg::cmd_type     cmd
);

   nhpw_pkg::state_type   state_ff, state_in;
   nhpw_pkg::div_cnt_type cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == nhpw_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nhpw_pkg::S_IDLE:    if (req_valid) state_in = nhpw_pkg::S_DECODE;
         nhpw_pkg::S_DECODE: begin
            if (status.op == nhpw_pkg::OP_UPDATE) state_in = nhpw_pkg::S_COUNT;
            else state_in = nhpw_pkg::S_FINISH;
         end
         nhpw_pkg::S_COUNT:   state_in = nhpw_pkg::S_MUL_OLD;
         nhpw_pkg::S_MUL_OLD: state_in = nhpw_pkg::S_MUL_NEW;
         nhpw_pkg::S_MUL_NEW: state_in = nhpw_pkg::S_AVG;
         nhpw_pkg::S_AVG:     state_in = nhpw_pkg::S_MUL_DEN;
         nhpw_pkg::S_MUL_DEN: state_in = nhpw_pkg::S_DEN;
         nhpw_pkg::S_DEN:     state_in = nhpw_pkg::S_START;
         nhpw_pkg::S_START: begin
            if (status.overflow) state_in = nhpw_pkg::S_FINISH;
            else state_in = nhpw_pkg::S_DIV;
         end
         nhpw_pkg::S_DIV:     if (cnt_ff == nhpw_pkg::DIV_LAST) state_in = nhpw_pkg::S_FINISH;
         nhpw_pkg::S_FINISH:  if (rsp_free) state_in = nhpw_pkg::S_IDLE;
         default:             state_in = nhpw_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = nhpw_pkg::MUL_AVG_ALPHA;
      case (state_ff)
         nhpw_pkg::S_IDLE:    cmd.capture = req_valid;
         nhpw_pkg::S_DECODE: begin
            cmd.set_delay   = (status.op == nhpw_pkg::OP_SET_DELAY);
            cmd.clear_state = (status.op == nhpw_pkg::OP_RESET);
         end
         nhpw_pkg::S_COUNT:   cmd.count_step = 1'b1;
         nhpw_pkg::S_MUL_OLD: cmd.mul_en = 1'b1;
         nhpw_pkg::S_MUL_NEW: begin
            cmd.acc_en  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = nhpw_pkg::MUL_COUNT_BETA;
         end
         nhpw_pkg::S_AVG:     cmd.avg_en = 1'b1;
         nhpw_pkg::S_MUL_DEN: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = nhpw_pkg::MUL_AVG_DELAY;
         end
         nhpw_pkg::S_DEN:     cmd.den_en = 1'b1;
         nhpw_pkg::S_START: begin
            cmd.sat_load = status.overflow;
            cmd.div_init = !status.overflow;
         end
         nhpw_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_last = (cnt_ff == nhpw_pkg::DIV_LAST);
         end
         nhpw_pkg::S_FINISH:  cmd.load_rsp = rsp_free;
         default:             cmd = '0;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.div_init) cnt_in = '0;
      else if (cmd.div_step) cnt_in = cnt_ff + 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nhpw_pkg::S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("nhpw_ctrl: result register overwritten");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("nhpw_ctrl: loaded result not presented");

   // one transaction at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("nhpw_ctrl: second transaction accepted while busy");

   assert property (@(posedge clock) disable iff (reset)
      cmd.div_last |=> (state_ff == nhpw_pkg::S_FINISH))
      else $error("nhpw_ctrl: divider did not hand over to finish");
`endif

endmodule

>>> dv/nexthop_pending_weight_tb.sv
`timescale 1ns / 100ps
// nexthop_pending_weight_tb: self-checking testbench for the next-hop pending-weight block.
// Uses nhpw_pkg for the operation codes, widths and constants; needs only the RTL.
module nexthop_pending_weight_tb;

   typedef struct {
      nhpw_pkg::op_type    op;
      logic                increment;
      logic                least_delay_known;
      nhpw_pkg::delay_type least_delay;
      nhpw_pkg::delay_type new_delay;
   } hop_req_type;

   typedef struct {
      nhpw_pkg::word_type  weight;
      logic                saturated;
      nhpw_pkg::count_type pending;
      nhpw_pkg::word_type  average;
   } hop_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = '0;
   logic        req_increment = 1'b0;
   logic        req_least_delay_known = 1'b0;
   logic [19:0] req_least_delay = '0;
   logic [19:0] req_new_delay = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_weight;
   logic        rsp_weight_saturated;
   logic [15:0] rsp_pending_count;
   logic [31:0] rsp_average_pending;

   nexthop_pending_weight DUT (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_increment         (req_increment),
      .req_least_delay_known (req_least_delay_known),
      .req_least_delay       (req_least_delay),
      .req_new_delay         (req_new_delay),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_weight            (rsp_weight),
      .rsp_weight_saturated  (rsp_weight_saturated),
      .rsp_pending_count     (rsp_pending_count),
      .rsp_average_pending   (rsp_average_pending)
   );

   always #4 clock = ~clock;

   // predictor state of the hop
   nhpw_pkg::alpha_type alpha_q16   = nhpw_pkg::ALPHA_RESET;
   nhpw_pkg::count_type pending_cnt = '0;
   nhpw_pkg::word_type  avg_q16     = nhpw_pkg::ONE_Q16;
   nhpw_pkg::delay_type hop_delay_q = '0;
   nhpw_pkg::word_type  weight_q16  = nhpw_pkg::ONE_Q16;

   hop_req_type hop_requests[$];
   hop_rsp_type expected_weights[$];
   hop_req_type in_flight_req;

   int unsigned items_sent   = 0;
   int unsigned results_done = 0;
   int unsigned error_count  = 0;
   int unsigned sat_seen     = 0;
   int unsigned floor_seen   = 0;
   int unsigned alpha_writes = 0;
   int unsigned send_wait    = 0;
   int unsigned stall_wait   = 0;
   logic        no_gaps      = 1'b0;

   task automatic flag_error(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic int unsigned draw_gap();
      return no_gaps ? 0 : $urandom_range(0, 14);
   endfunction

   // Apply one transaction to the hop state and return the result it produces.
   function automatic hop_rsp_type advance_hop_state(hop_req_type r);
      logic [63:0] a, avg, num, den, quo;
      hop_rsp_type o;
      o.saturated = 1'b0;
      case (r.op)
         nhpw_pkg::OP_UPDATE: begin
            if (r.increment) begin
               if (pending_cnt != nhpw_pkg::COUNT_MAX) pending_cnt++;
            end else if (pending_cnt != 0) begin
               pending_cnt--;
            end
            a   = 64'(alpha_q16);
            avg = ((64'(avg_q16) * a + 64'd32768) >> 16)
                  + 64'(pending_cnt) * (64'd65536 - a);
            if (avg > 64'(nhpw_pkg::WORD_MAX)) avg = 64'(nhpw_pkg::WORD_MAX);
            if (avg == 0) avg = 64'(nhpw_pkg::TENTH_Q16);
            avg_q16 = nhpw_pkg::word_type'(avg);
            if (r.least_delay_known && hop_delay_q != 0) begin
               num = 64'(hop_delay_q) << 32;
               den = avg * 64'(r.least_delay);
            end else begin
               num = 64'd1 << 32;
               den = avg;
            end
            if (den == 0) begin
               weight_q16  = nhpw_pkg::WORD_MAX;
               o.saturated = 1'b1;
            end else begin
               quo = num / den;
               if (quo > 64'(nhpw_pkg::WORD_MAX)) begin
                  weight_q16  = nhpw_pkg::WORD_MAX;
                  o.saturated = 1'b1;
               end else begin
                  weight_q16 = nhpw_pkg::word_type'(quo);
               end
            end
         end
         nhpw_pkg::OP_SET_DELAY: begin
            if (r.new_delay != 0) hop_delay_q = r.new_delay;
         end
         nhpw_pkg::OP_RESET: begin
            pending_cnt = '0;
            avg_q16     = nhpw_pkg::ONE_Q16;
            hop_delay_q = '0;
            weight_q16  = nhpw_pkg::ONE_Q16;
         end
         default: ;
      endcase
      o.weight  = weight_q16;
      o.pending = pending_cnt;
      o.average = avg_q16;
      return o;
   endfunction

   // request driver
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            expected_weights.push_back(advance_hop_state(in_flight_req));
            next_valid = 1'b0;
            send_wait  = draw_gap();
         end
         if (!next_valid) begin
            if (send_wait != 0) begin
               send_wait--;
            end else if (hop_requests.size() != 0) begin
               in_flight_req = hop_requests.pop_front();
               req_operation         <= in_flight_req.op;
               req_increment         <= in_flight_req.increment;
               req_least_delay_known <= in_flight_req.least_delay_known;
               req_least_delay       <= in_flight_req.least_delay;
               req_new_delay         <= in_flight_req.new_delay;
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      hop_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_weights.size() == 0) begin
               flag_error("result with no transaction outstanding");
            end else begin
               want = expected_weights.pop_front();
               results_done++;
               if (want.saturated) sat_seen++;
               if (want.average == nhpw_pkg::TENTH_Q16) floor_seen++;
               if (rsp_weight !== want.weight)
                  flag_error($sformatf("weight got %h want %h", rsp_weight, want.weight));
               if (rsp_weight_saturated !== want.saturated)
                  flag_error($sformatf("weight_saturated got %b want %b",
                                       rsp_weight_saturated, want.saturated));
               if (rsp_pending_count !== want.pending)
                  flag_error($sformatf("pending_count got %h want %h",
                                       rsp_pending_count, want.pending));
               if (rsp_average_pending !== want.average)
                  flag_error($sformatf("average_pending got %h want %h",
                                       rsp_average_pending, want.average));
            end
            stall_wait = draw_gap();
         end
         if (stall_wait != 0) begin
            stall_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic hop_req_type make_req(nhpw_pkg::op_type op, logic inc, logic known,
                                            nhpw_pkg::delay_type lowd,
                                            nhpw_pkg::delay_type newd);
      hop_req_type r;
      r.op                = op;
      r.increment         = inc;
      r.least_delay_known = known;
      r.least_delay       = lowd;
      r.new_delay         = newd;
      return r;
   endfunction

   function automatic hop_req_type random_req(int unsigned climb_pct);
      hop_req_type r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 78)      r.op = nhpw_pkg::OP_UPDATE;
      else if (pick < 92) r.op = nhpw_pkg::OP_SET_DELAY;
      else if (pick < 97) r.op = nhpw_pkg::OP_NONE;
      else                r.op = nhpw_pkg::OP_RESET;
      r.increment         = ($urandom_range(0, 99) < climb_pct);
      r.least_delay_known = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
         0:       r.least_delay = nhpw_pkg::delay_type'($urandom_range(0, 3));
         1:       r.least_delay = nhpw_pkg::delay_type'($urandom_range(0, 255));
         2:       r.least_delay = hop_delay_q;
         default: r.least_delay = nhpw_pkg::delay_type'($urandom);
      endcase
      case ($urandom_range(0, 2))
         0:       r.new_delay = '0;
         1:       r.new_delay = nhpw_pkg::delay_type'($urandom_range(1, 255));
         default: r.new_delay = nhpw_pkg::delay_type'($urandom);
      endcase
      return r;
   endfunction

   task automatic send(hop_req_type r);
      hop_requests.push_back(r);
      items_sent++;
   endtask

   // block until every queued transaction has produced its result
   task automatic wait_idle();
      while (results_done != items_sent) @(posedge clock);
   endtask

   task automatic write_alpha(nhpw_pkg::alpha_type v);
      wait_idle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      alpha_q16 = v;
      alpha_writes++;
   endtask

   initial begin
      nhpw_pkg::alpha_type alpha_plan [6];
      alpha_plan[0] = nhpw_pkg::ALPHA_RESET;
      alpha_plan[1] = 16'hFFFF;
      alpha_plan[2] = 16'h0000;
      alpha_plan[3] = 16'h8000;
      alpha_plan[4] = nhpw_pkg::alpha_type'($urandom_range(1, 65534));
      alpha_plan[5] = nhpw_pkg::alpha_type'($urandom_range(1, 65534));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default alpha, all operations and delay corner cases
      send(make_req(nhpw_pkg::OP_UPDATE,    1'b0, 1'b0, 20'h00000, 20'h00000)); // dec at zero
      send(make_req(nhpw_pkg::OP_UPDATE,    1'b1, 1'b1, 20'h00005, 20'h00000)); // no delay yet
      send(make_req(nhpw_pkg::OP_SET_DELAY, 1'b0, 1'b0, 20'h00000, 20'h00000)); // zero ignored
      send(make_req(nhpw_pkg::OP_SET_DELAY, 1'b1, 1'b1, 20'hFFFFF, 20'hFFFFF));
      send(make_req(nhpw_pkg::OP_UPDATE,    1'b1, 1'b1, 20'h00000, 20'h00000)); // zero divisor
      send(make_req(nhpw_pkg::OP_UPDATE,    1'b1, 1'b1, 20'h00001, 20'h00000)); // overflow
      send(make_req(nhpw_pkg::OP_UPDATE,    1'b1, 1'b1, 20'hFFFFF, 20'h00000));
      send(make_req(nhpw_pkg::OP_UPDATE,    1'b0, 1'b0, 20'hFFFFF, 20'hFFFFF));
      send(make_req(nhpw_pkg::OP_NONE,      1'b1, 1'b1, 20'hFFFFF, 20'hFFFFF));
      send(make_req(nhpw_pkg::OP_SET_DELAY, 1'b0, 1'b0, 20'h00000, 20'h00001));
      send(make_req(nhpw_pkg::OP_UPDATE,    1'b1, 1'b1, 20'hFFFFF, 20'h00000));
      send(make_req(nhpw_pkg::OP_RESET,     1'b1, 1'b1, 20'hFFFFF, 20'hFFFFF));
      send(make_req(nhpw_pkg::OP_UPDATE,    1'b1, 1'b1, 20'h00001, 20'h00000)); // delay cleared

      // alpha of zero: average follows the count, and a zero count floors to 0.1
      write_alpha(16'h0000);
      send(make_req(nhpw_pkg::OP_UPDATE,    1'b0, 1'b0, 20'h00000, 20'h00000));
      send(make_req(nhpw_pkg::OP_UPDATE,    1'b0, 1'b0, 20'h00000, 20'h00000));
      send(make_req(nhpw_pkg::OP_UPDATE,    1'b1, 1'b0, 20'h00000, 20'h00000));
      send(make_req(nhpw_pkg::OP_UPDATE,    1'b0, 1'b1, 20'h00003, 20'h00000));

      // alpha at full scale: average barely moves
      write_alpha(16'hFFFF);
      send(make_req(nhpw_pkg::OP_SET_DELAY, 1'b0, 1'b0, 20'h00000, 20'h003E8));
      send(make_req(nhpw_pkg::OP_UPDATE,    1'b1, 1'b1, 20'h003E8, 20'h00000));
      send(make_req(nhpw_pkg::OP_UPDATE,    1'b1, 1'b1, 20'h00064, 20'h00000));
      send(make_req(nhpw_pkg::OP_UPDATE,    1'b1, 1'b0, 20'h00064, 20'h00000));

      // random phases, one per alpha setting; phase 2 runs without idling
      for (int p = 0; p < 6; p++) begin
         write_alpha(alpha_plan[p]);
         no_gaps = (p == 2);
         for (int n = 0; n < 150; n++)
            send(random_req((p % 2 == 0) ? 68 : 42));
      end

      wait_idle();
      no_gaps = 1'b0;
      repeat (60) @(posedge clock);
      if (expected_weights.size() != 0)
         flag_error($sformatf("%0d results never arrived", expected_weights.size()));

      $display("Checked %0d transactions across %0d alpha writes", results_done, alpha_writes);
      $display("Saturated weights: %0d, averages floored to 0.1: %0d, errors: %0d",
               sat_seen, floor_seen, error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Timeout: %0d of %0d results received", results_done, items_sent);
      $display("Verification failed");
      $finish;
   end

endmodule
